// ===== hdl/cre_pkg.sv =====
// ----------------------------------------------------------------------------
// cre_pkg: shared types and constants for the carry-less range encoder
// Interval widths, limits and the normalization result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package cre_pkg;

	localparam int unsigned TotalBits = 16;
	localparam int unsigned CodeWidth = 32;
	localparam int unsigned CumWidth  = 16;
	localparam int unsigned FreqWidth = 17;
	localparam int unsigned ByteWidth = 8;
	localparam int unsigned MaxEmit   = 4;

	localparam logic [FreqWidth-1:0] TOTAL_CNT  = 17'h10000;
	localparam logic [CodeWidth-1:0] RANGE_INIT = 32'hFFFF_FFFF;

	localparam logic [0:0] ACT_ENCODE = 1'b0;
	localparam logic [0:0] ACT_FLUSH  = 1'b1;

	typedef struct packed {
		logic                 emit;
		logic [ByteWidth-1:0] code;
		logic [CodeWidth-1:0] low_next;
		logic [CodeWidth-1:0] range_next;
	} norm_t;

endpackage

`default_nettype wire

// ===== hdl/carryless_range_encoder_top.sv =====
// ----------------------------------------------------------------------------
// carryless_range_encoder_top: carry-less 32-bit range encoder, total 65536
// Sequencer around one shared multiplier and one normalization step.
// ----------------------------------------------------------------------------
// An encode item goes twice through the one 16x17 multiplier and then
// updates the range (skipped when range already equals the product), then
// emits its bytes one at a time through the normalization step and closes;
// the block is busy until its last byte is in the output register. A flush
// item emits the four bytes of low, one at a time. Bytes leave through a
// single output register, one per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module carryless_range_encoder_top
	import cre_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 sym_valid,
	output logic                      sym_stall,
	input  wire logic                 action,
	input  wire logic [CumWidth-1:0]  cum,
	input  wire logic [FreqWidth-1:0] freq,
	output logic                      byte_valid,
	input  wire logic                 byte_stall,
	output logic      [ByteWidth-1:0] out_byte,
	output logic                      last
);

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_MUL_LOW = 5'b00010,
		S_MUL_RNG = 5'b00100,
		S_NORM    = 5'b01000,
		S_FLUSH   = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [CodeWidth-1:0]   low_q;
	logic [CodeWidth-1:0]   range_q;
	logic [CumWidth-1:0]    cum_q;
	logic [FreqWidth-1:0]   freq_q;
	logic [2:0]             cnt_q;
	logic                   pend_v_q;
	logic [ByteWidth-1:0]   pend_q;
	logic                   out_v_q;
	logic [ByteWidth-1:0]   out_byte_q;
	logic                   last_q;

	logic                   accept;
	logic                   slot_free;
	logic                   out_load;
	logic [FreqWidth-1:0]   freq_nz;
	logic [FreqWidth:0]     share_end;
	logic [FreqWidth-1:0]   freq_clamp;
	logic                   mul_load;
	logic [FreqWidth-1:0]   mul_b;
	logic [CodeWidth-1:0]   prod_q;
	norm_t                  norm;
	logic                   do_emit;

	assign sym_stall  = (state_q != S_IDLE);
	assign accept     = sym_valid && !sym_stall;
	assign slot_free  = !out_v_q || !byte_stall;
	assign out_load   = slot_free && ((state_q == S_FLUSH) || (state_q == S_NORM && pend_v_q));
	assign byte_valid = out_v_q;
	assign out_byte   = out_byte_q;
	assign last       = last_q;

	always_comb begin
		freq_nz   = (freq == '0) ? FreqWidth'(1) : freq;
		share_end = {2'b00, cum} + {1'b0, freq_nz};
		if (share_end > {1'b0, TOTAL_CNT}) begin
			freq_clamp = TOTAL_CNT - {1'b0, cum};
		end else begin
			freq_clamp = freq_nz;
		end
	end

	assign mul_load = (state_q == S_MUL_LOW) || (state_q == S_MUL_RNG);
	assign mul_b    = (state_q == S_MUL_LOW) ? {1'b0, cum_q} : freq_q;

	cre_mul u_mul (
		.clk    (clk),
		.load   (mul_load),
		.a      (range_q[CodeWidth-1:TotalBits]),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	cre_norm u_norm (
		.low   (low_q),
		.range (range_q),
		.res   (norm)
	);

	assign do_emit = norm.emit && (cnt_q != 3'(MaxEmit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			low_q    <= '0;
			range_q  <= RANGE_INIT;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (slot_free) begin
				out_v_q <= out_load;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q    <= '0;
						pend_v_q <= 1'b0;
						if (action == ACT_FLUSH) begin
							state_q <= S_FLUSH;
						end else begin
							state_q <= S_MUL_LOW;
						end
					end
				end
				S_MUL_LOW: begin
					state_q <= S_MUL_RNG;
				end
				S_MUL_RNG: begin
					low_q   <= low_q + prod_q;
					state_q <= S_NORM;
				end
				S_NORM: begin
					if (cnt_q == '0 && !pend_v_q && range_q != prod_q) begin
						range_q <= prod_q;
					end else if (slot_free) begin
						if (do_emit) begin
							low_q    <= norm.low_next;
							range_q  <= norm.range_next;
							cnt_q    <= cnt_q + 3'd1;
							pend_v_q <= 1'b1;
						end else begin
							pend_v_q <= 1'b0;
							state_q  <= S_IDLE;
						end
					end
				end
				S_FLUSH: begin
					if (slot_free) begin
						cnt_q <= cnt_q + 3'd1;
						if (cnt_q == 3'(MaxEmit - 1)) begin
							low_q   <= '0;
							range_q <= RANGE_INIT;
							state_q <= S_IDLE;
						end else begin
							low_q <= {low_q[CodeWidth-ByteWidth-1:0], {ByteWidth{1'b0}}};
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cum_q  <= cum;
			freq_q <= freq_clamp;
		end
		if (state_q == S_NORM && slot_free && do_emit) begin
			pend_q <= norm.code;
		end
		if (slot_free) begin
			if (state_q == S_FLUSH) begin
				out_byte_q <= low_q[CodeWidth-1:CodeWidth-ByteWidth];
				last_q     <= (cnt_q == 3'(MaxEmit - 1));
			end else if (state_q == S_NORM) begin
				out_byte_q <= pend_q;
				last_q     <= !do_emit;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cre_mul.sv =====
// ----------------------------------------------------------------------------
// cre_mul: shared registered multiplier
// Multiplies the range quotient by cum or freq; product held in a register.
// ----------------------------------------------------------------------------
`default_nettype none

module cre_mul
	import cre_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 load,
	input  wire logic [TotalBits-1:0] a,
	input  wire logic [FreqWidth-1:0] b,
	output logic      [CodeWidth-1:0] prod_q
);

	logic [TotalBits+FreqWidth-1:0] full;

	assign full = {{FreqWidth{1'b0}}, a} * {{TotalBits{1'b0}}, b};

	// r <= 0xFFFF and b <= 0x10000, so the product fits 32 bits
	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= full[CodeWidth-1:0];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/cre_norm.sv =====
// ----------------------------------------------------------------------------
// cre_norm: one normalization step
// Decides whether the top byte of low is due and forms the shifted interval.
// ----------------------------------------------------------------------------
`default_nettype none

module cre_norm
	import cre_pkg::*;
(
	input  wire logic [CodeWidth-1:0] low,
	input  wire logic [CodeWidth-1:0] range,
	output norm_t                     res
);

	logic [CodeWidth:0]     sum;
	logic [CodeWidth:0]     diff;
	logic                   settled;
	logic                   small_rng;
	logic [TotalBits-1:0]   neg_low;

	always_comb begin
		sum       = {1'b0, low} + {1'b0, range};
		diff      = {1'b0, low} ^ sum;
		settled   = (diff[CodeWidth:CodeWidth-ByteWidth] == '0);
		small_rng = (range[CodeWidth-1:TotalBits] == '0);
		neg_low   = (~low[TotalBits-1:0]) + 1'b1;

		res.emit     = settled | small_rng;
		res.code     = low[CodeWidth-1:CodeWidth-ByteWidth];
		res.low_next = {low[CodeWidth-ByteWidth-1:0], {ByteWidth{1'b0}}};
		if (settled) begin
			res.range_next = {range[CodeWidth-ByteWidth-1:0], {ByteWidth{1'b0}}};
		end else begin
			res.range_next = {{ByteWidth{1'b0}}, neg_low, {ByteWidth{1'b0}}};
		end
	end

endmodule

`default_nettype wire
